// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SDA_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SDA_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define SDA_ASSERT_NXT_ALWAYS(name, clk, pre, post, msg) \
    name: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- src/sda_pkg.sv -----
// shared constants and types for the spike decoder accumulator
// no dependencies; used by the top level, sequencer and accumulator through scoped names
`timescale 1ns / 1ps

package sda_pkg;

    // default sizes
    localparam int NEURON_CNT_DEF  = 256;
    localparam int DELAY_SLOTS_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_SYNAPSE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;

    // synapse word layout
    localparam int SYN_TYPE_BIT = 20;
    localparam int SYN_IDX_LSB  = 21;
    localparam int SYN_IDX_MSB  = 31;
    localparam int SYN_IDX_W    = SYN_IDX_MSB - SYN_IDX_LSB + 1;

    // register map
    localparam int          PADDR_W       = 3;
    localparam int          REG_SEL_BIT   = 2;
    localparam logic        REG_STOP_TICK = 1'b0;
    localparam logic        REG_ACTIVE    = 1'b1;
    localparam logic [31:0] STOP_TICK_RST = 32'hFFFF_FFFF;
    localparam logic [8:0]  ACTIVE_RST    = 9'd256;

    // output scaling and saturation
    localparam int OUT_SHIFT = 8;
    localparam int OUT_MAX   = 32767;
    localparam int OUT_MIN   = -32768;

    // accumulator control from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctl;

    // result handoff from the sequencer
    typedef struct packed {
        logic load;
        logic done;
    } t_res_ctl;

endpackage

// ----- src/spike_decoder_accumulator_top.sv -----
// a tick walks the first min(active_neurons, NEURON_CNT) neuron rows, then loads its result item,
// one flag row and one decoder read and accumulated per cycle through the shared adder
// the result load waits while the output register is stalled; input is not ready during a tick,
// during an accepted synapse item's flag read-modify-write, or during the clearing pass
// reset: synchronous active low; a clearing pass zeroes the flag memory
// top level: apb registers, memories, output register; uses sda_pkg, sda_ram, sda_seq, sda_acc
`timescale 1ns / 1ps

module spike_decoder_accumulator_top #(
    parameter int NEURON_CNT  = sda_pkg::NEURON_CNT_DEF,
    parameter int DELAY_SLOTS = sda_pkg::DELAY_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sda_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [31:0]                 i_synapse_word,
    input  logic [7:0]                  i_decoder_index,
    input  logic signed [15:0]          i_decoder_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [15:0]          o_dec_sum,
    output logic                        o_done_res
);

    localparam int ADDR_W = (NEURON_CNT > 1) ? $clog2(NEURON_CNT) : 1;
    localparam int SLOT_W = $clog2(DELAY_SLOTS);
    localparam int SUM_W  = 17 + ADDR_W;

    logic [31:0] r_stop_tick;
    logic [8:0]  r_active;
    logic        cfg_wr;
    logic        reg_sel;

    logic                   flag_we;
    logic [ADDR_W-1:0]      flag_waddr;
    logic [DELAY_SLOTS-1:0] flag_wdata;
    logic [DELAY_SLOTS-1:0] flag_rdata;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   dec_we;
    logic [ADDR_W-1:0]      dec_waddr;
    logic [15:0]            dec_rdata;
    sda_pkg::t_acc_ctl      acc_ctl;
    sda_pkg::t_res_ctl      res_ctl;
    logic signed [15:0]     acc_value;
    logic                   out_free;

    logic               r_out_valid;
    logic signed [15:0] r_dec_sum;
    logic               r_done_res;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[sda_pkg::REG_SEL_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_tick <= sda_pkg::STOP_TICK_RST;
            r_active    <= sda_pkg::ACTIVE_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                sda_pkg::REG_STOP_TICK: r_stop_tick <= pwdata;
                sda_pkg::REG_ACTIVE:    r_active    <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            sda_pkg::REG_STOP_TICK: prdata = r_stop_tick;
            sda_pkg::REG_ACTIVE:    prdata = {23'd0, r_active};
            default:                prdata = '0;
        endcase
    end

    // per-neuron delay-slot flags
    sda_ram #(
        .WIDTH (DELAY_SLOTS),
        .DEPTH (NEURON_CNT),
        .AW    (ADDR_W)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (flag_rdata)
    );

    // per-neuron decoder weights
    sda_ram #(
        .WIDTH (16),
        .DEPTH (NEURON_CNT),
        .AW    (ADDR_W)
    ) u_dec_ram (
        .i_clk   (i_clk),
        .i_we    (dec_we),
        .i_waddr (dec_waddr),
        .i_wdata (i_decoder_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (dec_rdata)
    );

    sda_seq #(
        .NEURON_CNT  (NEURON_CNT),
        .DELAY_SLOTS (DELAY_SLOTS),
        .ADDR_W      (ADDR_W),
        .SLOT_W      (SLOT_W)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_synapse_word   (i_synapse_word),
        .i_decoder_index  (i_decoder_index),
        .i_stop_tick      (r_stop_tick),
        .i_active_neurons (r_active),
        .i_flag_rdata     (flag_rdata),
        .i_out_free       (out_free),
        .o_flag_we        (flag_we),
        .o_flag_waddr     (flag_waddr),
        .o_flag_wdata     (flag_wdata),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .o_dec_we         (dec_we),
        .o_dec_waddr      (dec_waddr),
        .o_acc            (acc_ctl),
        .o_res            (res_ctl)
    );

    sda_acc #(
        .SUM_W (SUM_W)
    ) u_acc (
        .i_clk   (i_clk),
        .i_ctl   (acc_ctl),
        .i_dec   (dec_rdata),
        .o_value (acc_value)
    );

    // result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ctl.load) begin
            r_dec_sum  <= acc_value;
            r_done_res <= res_ctl.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dec_sum   = r_dec_sum;
    assign o_done_res  = r_done_res;

endmodule

// ----- src/sda_ram.sv -----
// simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module sda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sda_acc.sv -----
// shared accumulate unit: one add per cycle, shift and saturate on readout
// depends on sda_pkg
`timescale 1ns / 1ps

module sda_acc #(
    parameter int SUM_W = 25
) (
    input  logic                i_clk,
    input  sda_pkg::t_acc_ctl   i_ctl,
    input  logic signed [15:0]  i_dec,
    output logic signed [15:0]  o_value
);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(sda_pkg::OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(sda_pkg::OUT_MIN);

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] shifted;

    // clear at tick start, add one flagged decoder per cycle
    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clear) begin
            n_sum = '0;
        end else if (i_ctl.add) begin
            n_sum = r_sum + SUM_W'(i_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // arithmetic shift and clamp to 16-bit signed
    always_comb begin
        shifted = r_sum >>> sda_pkg::OUT_SHIFT;
        if (shifted > SAT_MAX) begin
            o_value = 16'(SAT_MAX);
        end else if (shifted < SAT_MIN) begin
            o_value = 16'(SAT_MIN);
        end else begin
            o_value = 16'(shifted);
        end
    end

endmodule

// ----- src/sda_seq.sv -----
// sequencer: clear pass, synapse read-modify-write, decoder load, tick walk
// depends on sda_pkg
`timescale 1ns / 1ps

module sda_seq #(
    parameter int NEURON_CNT  = 256,
    parameter int DELAY_SLOTS = 16,
    parameter int ADDR_W      = 8,
    parameter int SLOT_W      = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_cmd,
    input  logic [31:0]            i_synapse_word,
    input  logic [7:0]             i_decoder_index,
    input  logic [31:0]            i_stop_tick,
    input  logic [8:0]             i_active_neurons,
    input  logic [DELAY_SLOTS-1:0] i_flag_rdata,
    input  logic                   i_out_free,
    output logic                   o_flag_we,
    output logic [ADDR_W-1:0]      o_flag_waddr,
    output logic [DELAY_SLOTS-1:0] o_flag_wdata,
    output logic                   o_rd_en,
    output logic [ADDR_W-1:0]      o_rd_addr,
    output logic                   o_dec_we,
    output logic [ADDR_W-1:0]      o_dec_waddr,
    output sda_pkg::t_acc_ctl      o_acc,
    output sda_pkg::t_res_ctl      o_res
);

    localparam int CNT_W       = ADDR_W + 1;
    localparam int SYN_IDX_W_L = sda_pkg::SYN_IDX_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SYN   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]        r_state,   n_state;
    logic [ADDR_W-1:0] r_addr,    n_addr;
    logic [CNT_W-1:0]  r_limit,   n_limit;
    logic [SLOT_W-1:0] r_slot,    n_slot;
    logic [31:0]       r_tick,    n_tick;
    logic              r_stopped, n_stopped;
    logic              r_done,    n_done;

    logic                   accept;
    logic [SYN_IDX_W_L-1:0] syn_idx;
    logic                   syn_ok;
    logic                   dec_ok;
    logic [31:0]            tick_next;
    logic                   tick_done;
    logic [SLOT_W-1:0]      slot_next;
    logic [31:0]            act32;
    logic [CNT_W-1:0]       lim;
    logic [CNT_W-1:0]       walk_next;
    logic [DELAY_SLOTS-1:0] cur_mask;
    logic [DELAY_SLOTS-1:0] syn_mask;

    // item decode and next-tick values
    always_comb begin
        accept    = i_in_valid && (r_state == ST_IDLE);
        syn_idx   = i_synapse_word[sda_pkg::SYN_IDX_MSB:sda_pkg::SYN_IDX_LSB];
        syn_ok    = !i_synapse_word[sda_pkg::SYN_TYPE_BIT]
                    && (32'(syn_idx) < 32'(NEURON_CNT));
        dec_ok    = 32'(i_decoder_index) < 32'(NEURON_CNT);
        tick_next = r_tick + 32'd1;
        tick_done = tick_next >= i_stop_tick;
        // slot follows the tick count, back to zero when the count wraps
        slot_next = (r_slot == SLOT_W'(DELAY_SLOTS - 1) || tick_next == '0) ? '0
                    : r_slot + SLOT_W'(1);
        act32     = 32'(i_active_neurons);
        lim       = (act32 > 32'(NEURON_CNT)) ? CNT_W'(NEURON_CNT) : CNT_W'(act32);
        walk_next = {1'b0, r_addr} + CNT_W'(1);
        cur_mask  = DELAY_SLOTS'(1) << r_slot;
        syn_mask  = DELAY_SLOTS'(1) << slot_next;
    end

    // state machine
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_limit      = r_limit;
        n_slot       = r_slot;
        n_tick       = r_tick;
        n_stopped    = r_stopped;
        n_done       = r_done;
        o_in_ready   = 1'b0;
        o_flag_we    = 1'b0;
        o_flag_waddr = r_addr;
        o_flag_wdata = '0;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_addr;
        o_dec_we     = 1'b0;
        o_dec_waddr  = ADDR_W'(i_decoder_index);
        o_acc        = '0;
        o_res.load   = 1'b0;
        o_res.done   = r_done;
        case (r_state)
            ST_CLEAR: begin
                // zero one flag row per cycle
                o_flag_we = 1'b1;
                if (r_addr == ADDR_W'(NEURON_CNT - 1)) begin
                    n_state = ST_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept && !r_stopped) begin
                    case (i_cmd)
                        sda_pkg::CMD_SYNAPSE: begin
                            if (syn_ok) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = ADDR_W'(syn_idx);
                                n_addr    = ADDR_W'(syn_idx);
                                n_state   = ST_SYN;
                            end
                        end
                        sda_pkg::CMD_TICK: begin
                            n_tick      = tick_next;
                            n_slot      = slot_next;
                            n_done      = tick_done;
                            n_stopped   = tick_done;
                            n_limit     = lim;
                            n_addr      = '0;
                            o_acc.clear = 1'b1;
                            if (lim == '0) begin
                                n_state = ST_OUT;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_state   = ST_WALK;
                            end
                        end
                        sda_pkg::CMD_LOAD: begin
                            o_dec_we = dec_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SYN: begin
                // set the flag for the slot of the next tick
                o_flag_we    = 1'b1;
                o_flag_wdata = i_flag_rdata | syn_mask;
                n_state      = ST_IDLE;
            end
            ST_WALK: begin
                // row r_addr is on the read port: clear its slot bit, add its decoder if that bit was set
                o_flag_we    = 1'b1;
                o_flag_wdata = i_flag_rdata & ~cur_mask;
                o_acc.add    = |(i_flag_rdata & cur_mask);
                if (walk_next < r_limit) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = ADDR_W'(walk_next);
                    n_addr    = ADDR_W'(walk_next);
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_res.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_addr    <= '0;
            r_slot    <= '0;
            r_tick    <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_slot    <= n_slot;
            r_tick    <= n_tick;
            r_stopped <= n_stopped;
        end
    end

    // per-tick values
    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_done  <= n_done;
    end

endmodule

// ----- src/sda_checker.sv -----
// port-level checker for the spike decoder accumulator, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_dec_sum,
    input logic               o_done_res
);

    // a stalled result item holds
    `SDA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_dec_sum) && $stable(o_done_res), "result item changed while stalled")

    // nothing follows the final result item
    `SDA_ASSERT_NXT(a_no_after_done, i_clk, i_rst_n, o_out_valid && i_out_ready && o_done_res, !o_out_valid, "result item after the run completed")

    // a new result only comes out of a tick, when input was not ready
    `SDA_ASSERT_IMP(a_out_from_tick, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result item appeared while idle")

    // reset empties the output and starts the flag clearing pass
    `SDA_ASSERT_NXT_ALWAYS(a_reset_state, i_clk, !i_rst_n, !o_out_valid && !o_in_ready, "bad state after reset")

endmodule

bind spike_decoder_accumulator_top sda_checker u_sda_checker (.*);
